@@ rtl/lss_pkg.sv @@
// Shared types and constants for the LIFO stack with search.
// Used by lifo_stack_with_search_core; no dependencies.
package lss_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int INDEX_W      = 4;
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 80;
  localparam int OUT_TUSER_W  = 2;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_FIND,
    S_HOLD
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   popped_value;
    logic [VALUE_W-1:0]   top_value;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
    logic                 found;
    logic [INDEX_W-1:0]   found_index;
  } res_t;

endpackage

@@ rtl/lifo_stack_with_search_core.sv @@
// Top level of the bounded LIFO stack with search.
// Depends on lss_pkg and lss_ram.
//
// One request is worked on at a time; in_tready is high while the block is idle.
// The stack lives in a single-port-read synchronous RAM, with the top entry
// mirrored in a register. Push, no-op, overflow, underflow and the pop of the
// last entry finish in the cycle the request is taken, with no RAM read. Any
// other pop passes through S_POP_WAIT, as the new top is read from the RAM. A
// find scans the RAM from the bottom, one entry per cycle on the single read
// port, and stops at the first match or after the top entry; a find on an
// empty stack finishes without a scan. A finished result that cannot enter a
// busy output register waits in a hold register, and no request is taken until
// it moves on; a request is taken while a result waits in the output register.
module lifo_stack_with_search_core #(
  parameter int DEPTH      = lss_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = lss_pkg::ELEM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lss_pkg::IN_TDATA_W-1:0]  in_tdata,   // value
  input  logic [lss_pkg::IN_TUSER_W-1:0]  in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // popped_value, top_value, entry_count, is_empty, found, found_index, zero pad
  output logic [lss_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lss_pkg::OUT_TUSER_W-1:0] out_tuser   // status
);
  import lss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  elem_t            top_r, top_nxt;
  elem_t            val_r, val_nxt;
  logic [AW-1:0]    chk_r, chk_nxt;
  res_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             hold_r, hold_nxt;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  elem_t            wr_data, rd_data;

  logic             in_acc, out_free, fin_valid;
  res_t             fin;
  op_t              op;
  elem_t            in_val;
  logic [CW-1:0]    cnt_dec, chk_inc;

  function automatic res_t mk_res(status_t st, elem_t popped, elem_t top,
                                  logic [CW-1:0] cnt, logic fnd, logic [AW-1:0] idx);
    res_t r;
    r.status       = st;
    r.popped_value = VALUE_W'(popped);
    r.top_value    = (cnt == '0) ? '0 : VALUE_W'(top);
    r.entry_count  = COUNT_W'(cnt);
    r.is_empty     = (cnt == '0);
    r.found        = fnd;
    r.found_index  = INDEX_W'(idx);
    return r;
  endfunction

  lss_ram #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign op        = op_t'(in_tuser);
  assign in_val    = elem_t'(in_tdata);
  assign cnt_dec   = count_r - CW'(1);
  assign chk_inc   = CW'(chk_r) + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    val_nxt       = val_r;
    chk_nxt       = chk_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    hold_nxt      = hold_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = in_val;
    rd_en         = 1'b0;
    rd_addr       = '0;
    fin_valid     = 1'b0;
    fin           = mk_res(ST_OK, '0, top_r, count_r, 1'b0, '0);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_PUSH: begin
              fin_valid = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                fin = mk_res(ST_OVERFLOW, '0, top_r, count_r, 1'b0, '0);
              end else begin
                wr_en     = 1'b1;
                top_nxt   = in_val;
                count_nxt = count_r + CW'(1);
                fin       = mk_res(ST_OK, '0, in_val, count_r + CW'(1), 1'b0, '0);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                fin_valid = 1'b1;
                fin       = mk_res(ST_UNDERFLOW, '0, '0, count_r, 1'b0, '0);
              end else begin
                count_nxt = cnt_dec;
                if (cnt_dec == '0) begin
                  fin_valid = 1'b1;
                  fin       = mk_res(ST_OK, top_r, '0, cnt_dec, 1'b0, '0);
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = AW'(cnt_dec - CW'(1));
                  val_nxt   = top_r;
                  state_nxt = S_POP_WAIT;
                end
              end
            end
            OP_FIND: begin
              if (count_r == '0) begin
                fin_valid = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                val_nxt   = in_val;
                chk_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        top_nxt   = rd_data;
        fin_valid = 1'b1;
        fin       = mk_res(ST_OK, val_r, rd_data, count_r, 1'b0, '0);
      end
      S_FIND: begin
        if (rd_data == val_r) begin
          fin_valid = 1'b1;
          fin       = mk_res(ST_OK, '0, top_r, count_r, 1'b1, chk_r);
        end else if (chk_inc == count_r) begin
          fin_valid = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(chk_inc);
          chk_nxt = AW'(chk_inc);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase

    if (fin_valid) begin
      if (out_free) begin
        out_nxt       = fin;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        hold_nxt  = fin;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    val_r  <= val_nxt;
    chk_r  <= chk_nxt;
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {5'b0, out_r.found_index, out_r.found, out_r.is_empty,
                       out_r.entry_count, out_r.top_value, out_r.popped_value};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_PUSH && count_r != CW'(DEPTH)) |=>
      count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the stack");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> out_valid_r)
    else $error("result held while output register free");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> (CW'(chk_r) < count_r))
    else $error("find scan past the top entry");

endmodule

@@ rtl/lss_ram.sv @@
// Stack storage: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module lss_ram #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [ELEM_WIDTH-1:0]            wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [ELEM_WIDTH-1:0]            rd_data
);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
